// ===== src/dbl_pkg.sv =====
// ----------------------------------------------------------------------------
// dbl_pkg
// shared types and constants for the debounce and long-press block
// ----------------------------------------------------------------------------
`default_nettype none

package dbl_pkg;

  localparam int TIME_W  = 32;
  localparam int CFG_W   = 16;
  localparam int PCT_W   = 7;
  localparam int PROD_W  = CFG_W + PCT_W;
  localparam int QCNT_W  = 3;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [CFG_W-1:0] HOLD_RST     = 16'd2000;
  localparam logic [PCT_W-1:0] PERCENT_FULL = 7'd100;

  localparam logic REG_DEBOUNCE = 1'b0;
  localparam logic REG_HOLD     = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ===== src/dbl_div.sv =====
// ----------------------------------------------------------------------------
// dbl_div
// shared restoring divider: (held * 100) / hold, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module dbl_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [dbl_pkg::CFG_W-1:0]     held,
  input  wire logic [dbl_pkg::CFG_W-1:0]     divisor,
  output logic      [dbl_pkg::PCT_W-1:0]     quotient,
  output dbl_pkg::div_stat_t                 status
);
  import dbl_pkg::*;

  logic [PROD_W-1:0] rem_r, rem_nxt;
  logic [PROD_W-1:0] dsh_r, dsh_nxt;
  logic [PCT_W-1:0]  q_r, q_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [PROD_W-1:0] prod;
  logic              fits;

  // held * 100 as shifted adds
  assign prod = {1'b0, held, 6'b0} + {2'b0, held, 5'b0} + {5'b0, held, 2'b0};
  assign fits = (rem_r >= dsh_r);

  always_comb begin
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = prod;
      dsh_nxt  = {1'b0, divisor, {(PCT_W-1){1'b0}}};
      q_nxt    = '0;
      cnt_nxt  = QCNT_W'(PCT_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (fits) begin
        rem_nxt = rem_r - dsh_r;
      end
      q_nxt   = {q_r[PCT_W-2:0], fits};
      dsh_nxt = dsh_r >> 1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quotient    = q_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

`default_nettype wire

// ===== src/button_debounce_long_press_core.sv =====
// ----------------------------------------------------------------------------
// button_debounce_long_press_core
// timestamp debounce with long-press detection and hold progress
//
//   channel | direction | signals
//   in_     | input     | in_valid, in_ready, in_now_ms, in_raw_level, in_portal_active
//   out_    | output    | out_valid, out_ready, out_stable_pressed, out_open_request,
//           |           | out_hold_percent
//   cfg_    | input     | cfg_we, cfg_index, cfg_wdata
//
// one transaction at a time: debounce, hold, then out_valid if no percentage is needed;
// start and divide come first when the shared divider runs its 7 quotient steps
// in_ready is low from accept until the result transaction completes
// out_valid holds with stable payload while out_ready is low
// synchronous reset clears the debounce state and loads the register defaults
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_long_press_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [dbl_pkg::TIME_W-1:0]    in_now_ms,
  input  wire logic                          in_raw_level,
  input  wire logic                          in_portal_active,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_stable_pressed,
  output logic                               out_open_request,
  output logic      [dbl_pkg::PCT_W-1:0]     out_hold_percent,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [dbl_pkg::CFG_W-1:0]     cfg_wdata
);
  import dbl_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEB   = 3'd1;
  localparam logic [2:0] S_HOLD  = 3'd2;
  localparam logic [2:0] S_START = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [CFG_W-1:0]  debounce_r, hold_r;
  logic [TIME_W-1:0] now_r;
  logic              raw_r, portal_r;
  logic              last_raw_r, last_raw_nxt;
  logic [TIME_W-1:0] rct_r, rct_nxt;
  logic              stable_r, stable_nxt;
  logic [TIME_W-1:0] pst_r, pst_nxt;
  logic              fired_r, fired_nxt;
  logic [CFG_W-1:0]  held_r, held_nxt;
  logic [PCT_W-1:0]  pct_r, pct_nxt;
  logic              req_r, req_nxt;
  logic [TIME_W-1:0] since_raw, held;
  logic              deb_hit, fire;
  logic              div_start;
  logic [PCT_W-1:0]  div_q;
  div_stat_t         div_stat;

  dbl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .held     (held_r),
    .divisor  (hold_r),
    .quotient (div_q),
    .status   (div_stat)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign div_start = (state_r == S_START);

  // debounce step
  always_comb begin
    last_raw_nxt = raw_r;
    rct_nxt      = (raw_r != last_raw_r) ? now_r : rct_r;
    since_raw    = now_r - rct_nxt;
    deb_hit      = (last_raw_nxt != stable_r) && (since_raw >= {16'b0, debounce_r});
  end

  // long-press step
  assign held = now_r - pst_r;
  assign fire = stable_r && !fired_r && (held >= {16'b0, hold_r});

  always_comb begin
    state_nxt  = state_r;
    stable_nxt = stable_r;
    pst_nxt    = pst_r;
    fired_nxt  = fired_r;
    held_nxt   = held_r;
    pct_nxt    = pct_r;
    req_nxt    = req_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DEB;
        end
      end
      S_DEB: begin
        if (deb_hit) begin
          stable_nxt = last_raw_nxt;
          pst_nxt    = last_raw_nxt ? now_r : '0;
          fired_nxt  = 1'b0;
        end
        state_nxt = S_HOLD;
      end
      S_HOLD: begin
        req_nxt  = fire && !portal_r;
        held_nxt = held[CFG_W-1:0];
        if (fire) begin
          fired_nxt = 1'b1;
        end
        if (!stable_r) begin
          pct_nxt   = '0;
          state_nxt = S_OUT;
        end else if (fire || fired_r) begin
          pct_nxt   = PERCENT_FULL;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_stat.done) begin
          pct_nxt   = div_q;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      now_r    <= in_now_ms;
      raw_r    <= in_raw_level;
      portal_r <= in_portal_active;
    end
    held_r <= held_nxt;
    pct_r  <= pct_nxt;
    req_r  <= req_nxt;
    if (!rst_n) begin
      state_r    <= S_IDLE;
      debounce_r <= DEBOUNCE_RST;
      hold_r     <= HOLD_RST;
      last_raw_r <= 1'b0;
      rct_r      <= '0;
      stable_r   <= 1'b0;
      pst_r      <= '0;
      fired_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      stable_r <= stable_nxt;
      pst_r    <= pst_nxt;
      fired_r  <= fired_nxt;
      if (state_r == S_DEB) begin
        last_raw_r <= last_raw_nxt;
        rct_r      <= rct_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_DEBOUNCE: debounce_r <= cfg_wdata;
          REG_HOLD:     hold_r     <= cfg_wdata;
          default:      debounce_r <= debounce_r;
        endcase
      end
    end
  end

  assign out_stable_pressed = stable_r;
  assign out_open_request   = req_r;
  assign out_hold_percent   = pct_r;

  // checks
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hold_percent <= PERCENT_FULL))
    else $error("hold percent above full");

  a_req_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_open_request) |->
      (out_stable_pressed && out_hold_percent == PERCENT_FULL))
    else $error("open request without full press");

  a_released_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stable_pressed) |-> (out_hold_percent == '0))
    else $error("nonzero percent while released");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == S_DIV))
    else $error("divider finished outside divide state");

  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> div_stat.busy)
    else $error("divider did not start");

endmodule

`default_nettype wire
